[hdl/vpa_pkg.sv]
// Shared constants and types for the Voigt profile approximation unit.
package vpa_pkg;

  // Width of y = x^2 in unsigned Q32.32; |x| never exceeds 2^31, so y < 2^63.
  localparam int YW = 63;

  typedef logic [YW-1:0] sq_t;

  // Quotient widths of the three restoring dividers.
  localparam int DIV1_QW = 32;  // c = (y - K1) / (y + K2), pure fraction
  localparam int DIV2_QW = 37;  // r = 21 / y, below 32.0
  localparam int DIV3_QW = 36;  // w = (1 + r) / (y + 1), below 16.0

  // Cycles through the exp(-y) unit.
  localparam int EXP_LAT = 41;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [31:0] K1_Q32  = 32'd3672197038;
  localparam logic [33:0] K2_Q32  = 34'd14688788152;

  // 21 * 2^64 / 2^DIV2_QW: the first partial remainder of 21 / y.
  localparam logic [31:0] DIV2_SEED = 32'd2818572288;

  localparam logic [30:0] P4_Q28  = 31'd1523102777;
  localparam logic [31:0] P3_Q28  = 32'd2471485243;
  localparam logic [30:0] P2_Q28  = 31'd1186753151;
  localparam logic [30:0] P1_Q28  = 31'd29984240;
  localparam logic [27:0] ISP_Q28 = 28'd151448488;

endpackage

[hdl/vpa_delay.sv]
// Enabled shift line that delays a word; the line shifts only while en is high.
module vpa_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

[hdl/vpa_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
module vpa_divider #(
  parameter int DW = 63,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] den_in,
  input  logic [QW-1:0] low_in,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] den_out
);

  logic [DW-1:0] rem_s [0:QW];
  logic [DW-1:0] den_s [0:QW];
  logic [QW-1:0] low_s [0:QW];
  logic [QW-1:0] quo_s [0:QW];

  assign rem_s[0] = rem_in;
  assign den_s[0] = den_in;
  assign low_s[0] = low_in;
  assign quo_s[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic        fit;

    always_comb begin
      trial = {rem_s[i], low_s[i][QW-1-i]};
      fit   = trial >= {1'b0, den_s[i]};
    end

    // Subtract when the divisor fits, shift the quotient bit in.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= fit ? DW'(trial - {1'b0, den_s[i]}) : DW'(trial);
        den_s[i+1] <= den_s[i];
        low_s[i+1] <= low_s[i];
        quo_s[i+1] <= {quo_s[i][QW-2:0], fit};
      end
    end
  end

  assign quo     = quo_s[QW];
  assign den_out = den_s[QW];

endmodule

[hdl/vpa_neg_exp.sv]
// Pipelined exp(-y): Taylor series in Horner form on y/32, then five squarings.
module vpa_neg_exp (
  input  logic          clk,
  input  logic          en,
  input  vpa_pkg::sq_t  y,
  output logic [28:0]   e28
);

  import vpa_pkg::*;

  localparam int Terms = 12;
  localparam int Squares = 5;

  logic [31:0] z_s [0:Terms];
  logic [32:0] e_s [0:Terms];
  logic [32:0] sq_s [0:Squares];
  logic        big;
  logic        big_d;

  assign big    = |y[YW-1:37];
  assign z_s[0] = y[36:5];
  assign e_s[0] = ONE_Q32;

  // Each term: multiply, divide by the term index, subtract from one.
  for (genvar k = 0; k < Terms; k++) begin : g_term
    localparam int unsigned Divn = Terms - k;
    localparam logic [35:0] Recip = 36'((64'd1 << 35) / Divn);

    logic [64:0] pa;
    logic [67:0] pb;
    logic [35:0] rem;
    logic [32:0] t;
    logic [31:0] xa, za, xb, zb, qb;

    assign pa  = 65'(z_s[k]) * 65'(e_s[k]);
    assign pb  = 68'(xa) * 68'(Recip);
    assign rem = 36'(xb) - 36'(qb) * 36'(Divn);
    assign t   = 33'(qb) + 33'(rem >= 36'(Divn));

    always_ff @(posedge clk) begin
      if (en) begin
        xa         <= pa[63:32];
        za         <= z_s[k];
        qb         <= pb[66:35];
        xb         <= xa;
        zb         <= za;
        e_s[k+1]   <= ONE_Q32 - t;
        z_s[k+1]   <= zb;
      end
    end
  end

  assign sq_s[0] = e_s[Terms];

  // Square back up to exp(-y); hold at one when the value is one.
  for (genvar j = 0; j < Squares; j++) begin : g_square
    logic [63:0] psq;

    assign psq = 64'(sq_s[j][31:0]) * 64'(sq_s[j][31:0]);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_s[j+1] <= sq_s[j][32] ? ONE_Q32 : {1'b0, psq[63:32]};
      end
    end
  end

  vpa_delay #(.WIDTH(1), .DEPTH(EXP_LAT)) u_big (
    .clk (clk),
    .en  (en),
    .d   (big),
    .q   (big_d)
  );

  // Drop to zero for y of 32 and above.
  assign e28 = big_d ? '0 : sq_s[Squares][32:4];

endmodule

[hdl/voigt_profile_approximation_unit.sv]
// Top level of the Voigt profile approximation unit.
//
// Usage: each input word carries offset_x (signed Q16.16) and damping_a
// (unsigned Q4.28) on the item channel; each result word carries profile_h
// (unsigned Q4.28, H(x,a)) and saturated on the result channel. Both
// channels use a valid/ready handshake; a word moves when both are high.
//
// The unit takes one word per cycle while the skid register is free; the
// longest path is the chain of restoring dividers, one quotient bit per
// stage: 21/y (37 stages), then (1 + 21/y)/(y + 1) (36 stages). The other
// branches run alongside and are delayed to meet it.
//
// The pipeline advances as a whole. When the receiver stalls, the word at
// the end is parked in a one-word skid register and the pipeline freezes
// until that word is taken; item_ready is low only while the skid holds a
// word. Reset empties the pipeline and the skid register; no result word
// is pending afterwards.
module voigt_profile_approximation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [31:0] offset_x,
  input  logic        [31:0] damping_a,
  output logic               result_valid,
  input  logic               result_ready,
  output logic        [31:0] profile_h,
  output logic               saturated
);

  import vpa_pkg::*;

  // Pipeline bookkeeping: square at level 1, dividers 2 and 3 in a row,
  // then three multiplies and the final sum.
  localparam int Latency   = 1 + DIV2_QW + DIV3_QW + 4;
  localparam int PolyDelay = DIV2_QW + DIV3_QW - DIV1_QW - 3;
  localparam int ADelay    = DIV2_QW + DIV3_QW + 2;
  localparam int FlagDelay = DIV2_QW + DIV3_QW + 3;
  localparam int ExpDelay  = DIV2_QW + DIV3_QW + 3 - EXP_LAT;

  logic               adv;
  logic [Latency-1:0] vld;

  // Skid register state.
  logic        skid_full;
  logic [31:0] skid_h;
  logic        skid_sat;

  logic [31:0] xraw;
  logic [31:0] mag;
  logic [63:0] mag_sq;
  sq_t         y1;
  logic [31:0] a1;
  logic        wing_en1;

  // Advance everything together while the skid register is free.
  assign adv        = !skid_full;
  assign item_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Latency-2:0], item_valid};
    end
  end

  // Level 1: magnitude and square. The most negative offset maps to 2^31.
  assign xraw   = offset_x;
  assign mag    = xraw[31] ? (~xraw + 32'd1) : xraw;
  assign mag_sq = 64'(mag) * 64'(mag);

  always_ff @(posedge clk) begin
    if (adv) begin
      y1 <= mag_sq[YW-1:0];
      a1 <= damping_a;
    end
  end

  // The wing term exists only for y >= 0.855.
  assign wing_en1 = y1 >= YW'(K1_Q32);

  // c = (y - 0.855) / (y + 3.42) in Q0.32.
  logic [DIV1_QW-1:0] q1;
  sq_t                den1_unused;

  vpa_divider #(.DW(YW), .QW(DIV1_QW)) u_div_c (
    .clk     (clk),
    .en      (adv),
    .rem_in  (y1 - YW'(K1_Q32)),
    .den_in  (y1 + YW'(K2_Q32)),
    .low_in  ('0),
    .quo     (q1),
    .den_out (den1_unused)
  );

  // r = 21 / y in Q.32; the divider also carries y along for the next one.
  logic [DIV2_QW-1:0] q2;
  sq_t                y38;

  vpa_divider #(.DW(YW), .QW(DIV2_QW)) u_div_r (
    .clk     (clk),
    .en      (adv),
    .rem_in  (YW'(DIV2_SEED)),
    .den_in  (y1),
    .low_in  ('0),
    .quo     (q2),
    .den_out (y38)
  );

  // w = (1 + r) / (y + 1) in Q.32.
  logic [DIV2_QW:0]   n3;
  logic [DIV3_QW-1:0] q3;
  sq_t                den3_unused;

  assign n3 = (DIV2_QW + 1)'(ONE_Q32) + (DIV2_QW + 1)'(q2);

  vpa_divider #(.DW(YW), .QW(DIV3_QW)) u_div_w (
    .clk     (clk),
    .en      (adv),
    .rem_in  (YW'(n3[DIV2_QW:4])),
    .den_in  (y38 + YW'(ONE_Q32)),
    .low_in  ({n3[3:0], 32'd0}),
    .quo     (q3),
    .den_out (den3_unused)
  );

  // Polynomial P(c) in Horner form, one multiply per stage.
  logic [27:0] c33, c34, c35, c36;
  logic [31:0] m1;
  logic [30:0] t2, t3, p37;
  logic [59:0] pm4, pm3;
  logic [58:0] pm2, pm1;
  logic [31:0] prod;

  assign c33  = q1[31:4];
  assign pm4  = 60'(P4_Q28) * 60'(c33);
  assign pm3  = 60'(m1) * 60'(c34);
  assign prod = pm3[59:28];
  assign pm2  = 59'(t2) * 59'(c35);
  assign pm1  = 59'(t3) * 59'(c36);

  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= P3_Q28 - pm4[59:28];
      c34 <= c33;
      // Clamp the inner difference at zero.
      t2  <= (prod >= 32'(P2_Q28)) ? '0 : 31'(32'(P2_Q28) - prod);
      c35 <= c34;
      t3  <= P1_Q28 + pm2[58:28];
      c36 <= c35;
      p37 <= pm1[58:28];
    end
  end

  // Align P, a, the wing flag and the exponential with the divider chain.
  logic [30:0] p75;
  logic [31:0] a76;
  logic        wing_en77;
  logic [28:0] e42;
  logic [28:0] e77;

  vpa_delay #(.WIDTH(31), .DEPTH(PolyDelay)) u_dly_p (
    .clk (clk),
    .en  (adv),
    .d   (p37),
    .q   (p75)
  );

  vpa_delay #(.WIDTH(32), .DEPTH(ADelay)) u_dly_a (
    .clk (clk),
    .en  (adv),
    .d   (a1),
    .q   (a76)
  );

  vpa_delay #(.WIDTH(1), .DEPTH(FlagDelay)) u_dly_flag (
    .clk (clk),
    .en  (adv),
    .d   (wing_en1),
    .q   (wing_en77)
  );

  vpa_neg_exp u_exp (
    .clk (clk),
    .en  (adv),
    .y   (y1),
    .e28 (e42)
  );

  vpa_delay #(.WIDTH(29), .DEPTH(ExpDelay)) u_dly_exp (
    .clk (clk),
    .en  (adv),
    .d   (e42),
    .q   (e77)
  );

  // Wing term a * P * w / sqrt(pi), floored to Q.28 after each product.
  logic [31:0] w74;
  logic [59:0] ps1;
  logic [62:0] ps2;
  logic [66:0] ps3;
  logic [31:0] s1;
  logic [34:0] s2;
  logic [38:0] wing77;

  assign w74 = q3[35:4];
  assign ps1 = 60'(w74) * 60'(ISP_Q28);
  assign ps2 = 63'(s1) * 63'(p75);
  assign ps3 = 67'(s2) * 67'(a76);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1     <= ps1[59:28];
      s2     <= ps2[62:28];
      wing77 <= ps3[66:28];
    end
  end

  // Final sum with saturation at the top of Q4.28.
  logic [39:0] hsum;
  logic        hsat;
  logic [31:0] h78;
  logic        sat78;

  assign hsum = 40'(e77) + (wing_en77 ? 40'(wing77) : 40'd0);
  assign hsat = |hsum[39:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      h78   <= hsat ? 32'hFFFF_FFFF : hsum[31:0];
      sat78 <= hsat;
    end
  end

  // Skid register: park the end word when the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (result_ready) begin
        skid_full <= 1'b0;
      end
    end else if (vld[Latency-1] && !result_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && vld[Latency-1] && !result_ready) begin
      skid_h   <= h78;
      skid_sat <= sat78;
    end
  end

  assign result_valid = skid_full || vld[Latency-1];
  assign profile_h    = skid_full ? skid_h : h78;
  assign saturated    = skid_full ? skid_sat : sat78;

  // A clipped word always reads as the maximum.
  a_sat_max : assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> profile_h == 32'hFFFF_FFFF)
    else $error("saturated word does not read as maximum");

  // The pipeline holds still while the skid register is occupied.
  a_freeze : assert property (@(posedge clk) disable iff (rst)
    skid_full |=> $stable(vld))
    else $error("pipeline moved while skid register was full");

  // A stalled end word is parked, never dropped.
  a_park : assert property (@(posedge clk) disable iff (rst)
    vld[Latency-1] && !skid_full && !result_ready |=> skid_full)
    else $error("stalled result word was not parked");

endmodule
